// File: rtl/rhf_pkg.sv
// rhf_pkg: shared types, constants and character helpers for the request header framer
// no dependencies; imported by request_header_framer and the testbench
`timescale 1ns / 1ps

package rhf_pkg;

  localparam int BODY_MAX_DEF = 2048;
  localparam int BODY_LEN_W   = 12;
  localparam int VAL_W        = 60;

  // result kinds carried on out_tuser
  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_LINE = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // header value sub-phase
  typedef enum logic [3:0] {
    VP_NAME  = 4'b0001,
    VP_BLANK = 4'b0010,
    VP_DIGIT = 4'b0100,
    VP_SKIP  = 4'b1000
  } vphase_t;

  localparam logic [VAL_W-1:0] VAL_SAT     = 60'd999999999999999999;
  localparam logic [VAL_W-1:0] VAL_MUL_LIM = 60'd99999999999999999;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [79:0]  SES_NAME = "sessionid:";
  localparam logic [119:0] LEN_NAME = "content-length:";
  localparam int SES_NAME_LEN = 10;
  localparam int LEN_NAME_LEN = 15;

  localparam logic [23:0] METH_NAMES [8] = '{
    "HBT", "LGN", "RGT", "LGT", "SCU", "ADF", "RFR", "RCN"
  };

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } meth_hit_t;

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  // name characters by position, zero past the end
  function automatic logic [7:0] ses_char(logic [4:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    if (p < 5'(SES_NAME_LEN)) begin
      ch = SES_NAME[8*(SES_NAME_LEN-1-int'(p)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] len_char(logic [4:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    if (p < 5'(LEN_NAME_LEN)) begin
      ch = LEN_NAME[8*(LEN_NAME_LEN-1-int'(p)) +: 8];
    end
    return ch;
  endfunction

  function automatic meth_hit_t meth_lookup(logic [23:0] text);
    meth_hit_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (!r.hit && text == METH_NAMES[i]) begin
        r.hit = 1'b1;
        r.idx = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/request_header_framer.sv
// request_header_framer: byte-serial CR LF request line and header framer with body pass-through
// depends on rhf_pkg (kinds, phases, name tables, character helpers)
`timescale 1ns / 1ps

// channel | dir | handshake           | payload
// --------+-----+---------------------+-----------------------------------------------
// in_     | in  | in_tvalid/in_tready | in_tdata[7:0] rx_byte
// out_    | out | out_tvalid/out_tready | out_tdata: body_byte, method_code,
//         |     |                     |   session_value, body_length; out_tuser kind;
//         |     |                     |   out_tlast last_of_run
//
// one byte is accepted per cycle while in_tready is high; its whole parse step is done in the
// accept cycle and its first result lands in the output register on the same edge
// the last body byte of a request yields two items (body byte, then request complete);
// the second sits in a pending slot, which holds in_tready low for one output transfer
// in_tready = no pending item and (output register empty or being taken this cycle)
// rst_n is synchronous, active low; it clears the parser, the session value and the
// output side, no clearing pass is needed

module request_header_framer
  import rhf_pkg::*;
#(
  parameter int BODY_MAX = BODY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [7:0] body_byte, [10:8] method_code,
                                  // [70:11] session_value, [82:71] body_length, zero fill
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  // length and body count width: wide enough for the bound and for the 12-bit field
  localparam int LEN_NEED = $clog2(BODY_MAX + 1);
  localparam int LEN_W    = (LEN_NEED > BODY_LEN_W) ? LEN_NEED : BODY_LEN_W;

  localparam logic [1:0] CAND_SES = 2'b01;
  localparam logic [1:0] CAND_LEN = 2'b10;

  // parser state
  phase_t              phase_r,  phase_nxt;
  logic                cr_r,     cr_nxt;
  logic [4:0]          llen_r,   llen_nxt;
  logic [23:0]         mtext_r,  mtext_nxt;
  logic [1:0]          match_r,  match_nxt;
  vphase_t             vph_r,    vph_nxt;
  logic [VAL_W-1:0]    acc_r,    acc_nxt;
  logic [2:0]          meth_r,   meth_nxt;
  logic [VAL_W-1:0]    sess_r,   sess_nxt;
  logic [LEN_W-1:0]    len_r,    len_nxt;
  logic [LEN_W-1:0]    cnt_r,    cnt_nxt;

  // output register and pending second item
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [7:0]          out_byte_r;
  logic [2:0]          out_meth_r;
  logic [VAL_W-1:0]    out_sess_r;
  logic [BODY_LEN_W-1:0] out_len_r;
  logic                out_last_r;
  logic                pend_r;
  logic [2:0]          pend_meth_r;
  logic [BODY_LEN_W-1:0] pend_len_r;

  // results of this byte
  logic                emit1, emit2;
  kind_t               e_kind;
  logic [7:0]          e_byte;

  logic                in_fire;
  logic [7:0]          c;

  assign in_tready = !pend_r && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign c         = in_tdata;

  // one parse step
  always_comb begin
    logic             do_clear, do_restart;
    logic [4:0]       p;
    logic [7:0]       lc;
    logic [1:0]       m;
    logic [VAL_W-1:0] d;
    meth_hit_t        mh;
    logic [LEN_W-1:0] cnt_inc;

    phase_nxt = phase_r;
    cr_nxt    = cr_r;
    llen_nxt  = llen_r;
    mtext_nxt = mtext_r;
    match_nxt = match_r;
    vph_nxt   = vph_r;
    acc_nxt   = acc_r;
    meth_nxt  = meth_r;
    sess_nxt  = sess_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    emit1     = 1'b0;
    emit2     = 1'b0;
    e_kind    = KIND_BODY;
    e_byte    = 8'h00;
    do_clear  = 1'b0;
    do_restart = 1'b0;
    p         = llen_r;
    lc        = to_lower(c);
    m         = match_r;
    d         = VAL_W'(c - CH_0);
    mh        = meth_lookup(mtext_r);
    cnt_inc   = cnt_r + 1'b1;

    if (phase_r == PH_BODY) begin
      // body bytes pass straight through, CR and LF included
      emit1   = 1'b1;
      e_kind  = KIND_BODY;
      e_byte  = c;
      cnt_nxt = cnt_inc;
      if (cnt_inc >= len_r) begin
        emit2      = 1'b1;
        do_restart = 1'b1;
      end
    end else if (c == CH_CR) begin
      if (cr_r) begin
        emit1 = 1'b1; e_kind = KIND_BAD; do_restart = 1'b1;
      end else begin
        cr_nxt = 1'b1;
      end
    end else if (c == CH_LF) begin
      if (!cr_r) begin
        // bare line feed
        emit1 = 1'b1; e_kind = KIND_BAD; do_restart = 1'b1;
      end else if (phase_r != PH_HEAD) begin
        // request line must be exactly one method name
        if (llen_r == 5'd3 && mh.hit) begin
          meth_nxt  = mh.idx;
          phase_nxt = PH_HEAD;
          do_clear  = 1'b1;
        end else begin
          emit1 = 1'b1; e_kind = KIND_BAD; do_restart = 1'b1;
        end
      end else if (llen_r == 5'd0) begin
        // empty line ends the headers
        if (len_r != '0) begin
          phase_nxt = PH_BODY;
          cnt_nxt   = '0;
          do_clear  = 1'b1;
        end else begin
          emit1 = 1'b1; e_kind = KIND_DONE; do_restart = 1'b1;
        end
      end else begin
        do_clear = 1'b1;
        if (vph_r != VP_NAME) begin
          if (match_r[0]) begin
            sess_nxt = acc_r;
          end else if (match_r[1]) begin
            if (acc_r > VAL_W'(BODY_MAX)) begin
              emit1 = 1'b1; e_kind = KIND_BAD; do_restart = 1'b1;
            end else begin
              len_nxt = acc_r[LEN_W-1:0];
            end
          end
        end
      end
    end else if (cr_r) begin
      // bare carriage return, the byte itself is dropped
      emit1 = 1'b1; e_kind = KIND_BAD; do_restart = 1'b1;
    end else begin
      if (llen_r != 5'd31) begin
        llen_nxt = llen_r + 5'd1;
      end
      if (phase_r != PH_HEAD) begin
        if (p < 5'd3) begin
          mtext_nxt[8*(2-int'(p[1:0])) +: 8] = to_upper(c);
        end
      end else if (vph_r == VP_NAME) begin
        if (m[0] && !(p < 5'(SES_NAME_LEN) && lc == ses_char(p))) m = m & ~CAND_SES;
        if (m[1] && !(p < 5'(LEN_NAME_LEN) && lc == len_char(p))) m = m & ~CAND_LEN;
        match_nxt = m;
        if ((m[0] && p == 5'(SES_NAME_LEN - 1)) || (m[1] && p == 5'(LEN_NAME_LEN - 1))) begin
          vph_nxt = VP_BLANK;
        end
      end else if (vph_r != VP_SKIP) begin
        if (c >= CH_0 && c <= CH_9) begin
          // acc * 10 + digit, saturating
          if (acc_r > VAL_MUL_LIM) begin
            acc_nxt = VAL_SAT;
          end else begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + d;
          end
          vph_nxt = VP_DIGIT;
        end else if (vph_r == VP_BLANK && (c == CH_SP || c == CH_TAB)) begin
          vph_nxt = VP_BLANK;
        end else begin
          vph_nxt = VP_SKIP;
        end
      end
    end

    if (do_clear || do_restart) begin
      cr_nxt    = 1'b0;
      llen_nxt  = 5'd0;
      mtext_nxt = 24'd0;
      match_nxt = CAND_SES | CAND_LEN;
      vph_nxt   = VP_NAME;
      acc_nxt   = '0;
    end
    if (do_restart) begin
      phase_nxt = PH_LINE;
      meth_nxt  = 3'd0;
      len_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      cr_r    <= 1'b0;
      llen_r  <= 5'd0;
      mtext_r <= 24'd0;
      match_r <= CAND_SES | CAND_LEN;
      vph_r   <= VP_NAME;
      acc_r   <= '0;
      meth_r  <= 3'd0;
      sess_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cr_r    <= cr_nxt;
      llen_r  <= llen_nxt;
      mtext_r <= mtext_nxt;
      match_r <= match_nxt;
      vph_r   <= vph_nxt;
      acc_r   <= acc_nxt;
      meth_r  <= meth_nxt;
      sess_r  <= sess_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // output register; value fields show the registers before any restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (pend_r && out_tready) begin
      // request complete after the last body byte
      out_valid_r <= 1'b1;
      out_kind_r  <= KIND_DONE;
      out_byte_r  <= 8'h00;
      out_meth_r  <= pend_meth_r;
      out_sess_r  <= sess_r;
      out_len_r   <= pend_len_r;
      out_last_r  <= 1'b1;
      pend_r      <= 1'b0;
    end else if (in_fire && emit1) begin
      out_valid_r <= 1'b1;
      out_kind_r  <= e_kind;
      out_byte_r  <= e_byte;
      out_meth_r  <= meth_r;
      out_sess_r  <= sess_r;
      out_len_r   <= len_r[BODY_LEN_W-1:0];
      out_last_r  <= !emit2;
      pend_r      <= emit2;
      pend_meth_r <= meth_r;
      pend_len_r  <= len_r[BODY_LEN_W-1:0];
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_len_r, out_sess_r, out_meth_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // a pending item always sits behind a full output register
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && !in_tready)
    else $error("pending item without full output register");

  // the pending item follows the body byte as a final request complete
  a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_tready |=> out_valid_r && out_tuser == KIND_DONE && out_tlast)
    else $error("pending item not delivered as request complete");

  // a byte that leaves a pending item must have been the last body byte
  a_pend_from_body: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |-> out_tuser == KIND_BODY && !out_tlast && phase_r == PH_LINE)
    else $error("second item not caused by the final body byte");

  // in the body the count stays below a nonzero length
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> len_r != '0 && cnt_r < len_r)
    else $error("body count out of range");
`endif

endmodule

// File: verif/testbench.sv
// testbench for request_header_framer: byte streams of well-formed, broken and noisy requests
// are driven in, every result item is checked against a cycle-free model of the framer
// depends on rhf_pkg (kind_t, phase_t, vphase_t) and rtl/request_header_framer.sv
`timescale 1ns / 1ps

module testbench
  import rhf_pkg::*;
;
  localparam bit [7:0] CR = 8'h0d;
  localparam bit [7:0] LF = 8'h0a;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 550;

  // one result item as the framer should send it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  body;
    logic [2:0]  meth;
    logic [59:0] session;
    logic [11:0] blen;
    logic        last;
  } framer_result_t;

  // parses the byte stream the way the framer should and keeps the results still due
  class request_scoreboard;
    localparam bit [63:0] SES_SAT = 64'd999999999999999999;
    localparam int        LEN_BOUND = 2048;

    phase_t      phase;
    bit          cr_seen;
    bit [4:0]    line_len;
    bit [23:0]   meth_text;
    bit          ses_ok;
    bit          len_ok;
    vphase_t     vph;
    bit [63:0]   acc;
    bit [2:0]    meth;
    bit [59:0]   session;
    bit [11:0]   blen;
    bit [11:0]   body_cnt;
    string       ses_name;
    string       len_name;

    framer_result_t due[$];
    int errors;

    function new();
      ses_name = "sessionid:";
      len_name = "content-length:";
      session  = '0;
      errors   = 0;
      restart();
    endfunction

    static function string method_name(int i);
      case (i)
        0: return "HBT";
        1: return "LGN";
        2: return "RGT";
        3: return "LGT";
        4: return "SCU";
        5: return "ADF";
        6: return "RFR";
        default: return "RCN";
      endcase
    endfunction

    function bit [7:0] up(bit [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? (c ^ 8'h20) : c;
    endfunction

    function bit [7:0] down(bit [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? (c ^ 8'h20) : c;
    endfunction

    function void clear_line();
      cr_seen   = 1'b0;
      line_len  = '0;
      meth_text = '0;
      ses_ok    = 1'b1;
      len_ok    = 1'b1;
      vph       = VP_NAME;
      acc       = '0;
    endfunction

    function void restart();
      clear_line();
      phase    = PH_LINE;
      meth     = '0;
      blen     = '0;
      body_cnt = '0;
    endfunction

    function void emit(kind_t k, bit [7:0] b);
      framer_result_t r;
      r.kind    = k;
      r.body    = b;
      r.meth    = meth;
      r.session = session;
      r.blen    = blen;
      r.last    = 1'b0;
      due.push_back(r);
    endfunction

    function void reject();
      emit(KIND_BAD, 8'h00);
      restart();
    endfunction

    function void take_char(bit [7:0] c);
      int p;
      bit [7:0] lc;
      bit [63:0] d;
      p = line_len;
      if (line_len < 31) line_len++;
      if (phase != PH_HEAD) begin
        if (p < 3) meth_text[8*(2-p) +: 8] = up(c);
        return;
      end
      if (vph == VP_NAME) begin
        lc = down(c);
        if (ses_ok && !(p < 10 && lc == ses_name[p])) ses_ok = 1'b0;
        if (len_ok && !(p < 15 && lc == len_name[p])) len_ok = 1'b0;
        if (ses_ok && p == 9) vph = VP_BLANK;
        if (len_ok && p == 14) vph = VP_BLANK;
        return;
      end
      if (vph == VP_SKIP) return;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = 64'(c - 8'h30);
        if (acc > (SES_SAT - d) / 10) acc = SES_SAT;
        else acc = acc * 10 + d;
        vph = VP_DIGIT;
      end else if (!(vph == VP_BLANK && (c == 8'h20 || c == 8'h09))) begin
        vph = VP_SKIP;
      end
    endfunction

    function void end_line();
      string n;
      if (phase != PH_HEAD) begin
        if (line_len == 3) begin
          for (int i = 0; i < 8; i++) begin
            n = method_name(i);
            if (meth_text == {n[0], n[1], n[2]}) begin
              meth  = 3'(i);
              phase = PH_HEAD;
              clear_line();
              return;
            end
          end
        end
        reject();
        return;
      end
      if (line_len == 0) begin
        if (blen != 0) begin
          phase    = PH_BODY;
          body_cnt = '0;
          clear_line();
        end else begin
          emit(KIND_DONE, 8'h00);
          restart();
        end
        return;
      end
      if (vph != VP_NAME) begin
        if (ses_ok) begin
          session = acc[59:0];
        end else if (len_ok) begin
          if (acc > LEN_BOUND) begin
            reject();
            return;
          end
          blen = acc[11:0];
        end
      end
      clear_line();
    endfunction

    // one accepted byte: work out the result items it causes
    function void note_rx_byte(bit [7:0] c);
      int n_old;
      n_old = due.size();
      if (phase == PH_BODY) begin
        emit(KIND_BODY, c);
        body_cnt++;
        if (body_cnt >= blen) begin
          emit(KIND_DONE, 8'h00);
          restart();
        end
      end else if (c == CR) begin
        if (cr_seen) reject();
        else cr_seen = 1'b1;
      end else if (c == LF) begin
        if (cr_seen) end_line();
        else reject();
      end else if (cr_seen) begin
        reject();
      end else begin
        take_char(c);
      end
      if (due.size() > n_old) due[due.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [87:0] data, logic last);
      framer_result_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result item: kind %0d data %h last %0d", kind, data, last);
        return;
      end
      e = due[0];
      due.delete(0);
      if (kind !== e.kind || data[7:0] !== e.body || data[10:8] !== e.meth ||
          data[70:11] !== e.session || data[82:71] !== e.blen || data[87:83] !== 5'd0 ||
          last !== e.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (expected/actual): kind %0d/%0d byte %h/%h method %0d/%0d",
                   e.kind, kind, e.body, data[7:0], e.meth, data[10:8]);
          $display("  session %0d/%0d length %0d/%0d last %0d/%0d fill 0/%h",
                   e.session, data[70:11], e.blen, data[82:71], e.last, last, data[87:83]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  request_scoreboard sb;
  bit [7:0] tx_q[$];
  int  items_sent;
  int  idle_cycles;
  int  rx_hold;
  bit  steady;

  request_header_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly no gap, some short ones, a few long; none at all in a steady stretch
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // items are counted and checked at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_rx_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25) rx_hold = idle_gap();
    end
  end

  task automatic send_byte(input bit [7:0] b);
    int g;
    g = idle_gap();
    repeat (g) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_all();
    bit [7:0] b;
    while (tx_q.size() > 0) begin
      b = tx_q[0];
      tx_q.delete(0);
      send_byte(b);
    end
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
  endfunction

  function automatic void push_crlf();
    tx_q.push_back(CR);
    tx_q.push_back(LF);
  endfunction

  // letters flip case at random, the framer ignores case in names
  function automatic void push_mixed(string s);
    bit [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) && $urandom_range(0, 1))
        c = c ^ 8'h20;
      tx_q.push_back(c);
    end
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(0, 2)) tx_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
  endfunction

  function automatic bit [7:0] line_char();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CR || c == LF);
    return c;
  endfunction

  function automatic void push_method_line();
    string n;
    int    v;
    n = request_scoreboard::method_name($urandom_range(0, 7));
    if ($urandom_range(0, 9) != 0) begin
      push_mixed(n);
    end else begin
      v = $urandom_range(0, 4);
      case (v)
        0: begin  // one letter off
          n[$urandom_range(0, 2)] = 8'($urandom_range(8'h41, 8'h5a));
          push_str(n);
        end
        1: begin push_str(n); tx_q.push_back(line_char()); end
        2: begin tx_q.push_back(n[0]); tx_q.push_back(n[1]); end
        3: begin tx_q.push_back(n[0]); tx_q.push_back(8'h00); tx_q.push_back(n[2]); end
        default: repeat ($urandom_range(20, 40)) tx_q.push_back(line_char());
      endcase
    end
    push_crlf();
  endfunction

  function automatic void push_session_header();
    int r;
    int nd;
    push_mixed("sessionID:");
    push_blanks();
    r = $urandom_range(0, 9);
    if (r == 0) nd = 0;
    else if (r < 7) nd = $urandom_range(1, 6);
    else nd = $urandom_range(17, 21);
    if ($urandom_range(0, 9) == 0) tx_q.push_back($urandom_range(0, 1) ? "-" : "+");
    repeat (nd) tx_q.push_back(8'($urandom_range(8'h30, 8'h39)));
    if ($urandom_range(0, 7) == 0) push_str(" 77x");
    push_crlf();
  endfunction

  // returns the value the framer will take from the header, -1 when it is over the bound
  function automatic int push_length_header(int v, bit zeros, bit sign);
    push_mixed("Content-Length:");
    push_blanks();
    if (sign) tx_q.push_back("-");
    if (zeros) push_str("00");
    push_str($sformatf("%0d", v));
    if ($urandom_range(0, 7) == 0) push_str("\tjunk");
    push_crlf();
    if (sign) return 0;
    return (v > 2048) ? -1 : v;
  endfunction

  task automatic build_request();
    int  body_len;
    int  got;
    int  r;
    int  idx;
    bit  doomed;
    body_len = 0;
    doomed   = 1'b0;
    push_method_line();
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        push_session_header();
      end else if (r < 6) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          got = push_length_header($urandom_range(0, 6), 1'b0, $urandom_range(0, 19) == 0);
        end else if (r < 76) begin
          got = push_length_header($urandom_range(20, 60), 1'b0, 1'b0);
        end else if (r < 84) begin
          // the bound itself, then a repeat that wins
          got = push_length_header(2048, 1'b0, 1'b0);
          got = push_length_header($urandom_range(0, 6), 1'b0, 1'b0);
        end else if (r < 90) begin
          got = push_length_header(2049, 1'b0, 1'b0);
        end else if (r < 94) begin
          got = push_length_header($urandom_range(2050, 99999), 1'b0, 1'b0);
        end else begin
          got = push_length_header($urandom_range(0, 6), 1'b1, 1'b0);
        end
        if (got < 0) doomed = 1'b1;
        else body_len = got;
      end else if (r == 6) begin
        // names that only nearly match are ignored
        case ($urandom_range(0, 2))
          0: push_mixed("session: 12");
          1: push_mixed("Content-Lengt: 3");
          default: push_mixed("sessionIDx: 4");
        endcase
        push_crlf();
      end else begin
        repeat ($urandom_range(1, 40)) tx_q.push_back(line_char());
        push_crlf();
      end
    end
    push_crlf();
    if (!doomed) repeat (body_len) tx_q.push_back(8'($urandom_range(0, 255)));
    // a broken request: a stray CR or LF, or a lost byte
    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, tx_q.size() - 1);
      case ($urandom_range(0, 2))
        0: tx_q.insert(idx, CR);
        1: tx_q.insert(idx, LF);
        default: tx_q.delete(idx);
      endcase
    end
  endtask

  function automatic void build_noise();
    int r;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 9);
      if (r < 4) tx_q.push_back(CR);
      else if (r < 7) tx_q.push_back(LF);
      else tx_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    rx_hold     = 0;
    steady      = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: mixed-case method with no headers, bare LF, CR CR, CR then a letter,
    // empty request line, request line of a zero byte and an all-ones byte
    push_str("rCn");
    push_crlf();
    push_crlf();
    tx_q.push_back(LF);
    tx_q.push_back(CR);
    tx_q.push_back(CR);
    tx_q.push_back(CR);
    tx_q.push_back("Z");
    push_crlf();
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hff);
    push_crlf();
    send_all();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 99) < 78) build_request();
      else build_noise();
      send_all();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

// File: request_header_framer.f
rtl/rhf_pkg.sv
rtl/request_header_framer.sv
verif/testbench.sv
